// ===== rtl/e2ct_pkg.sv =====
package e2ct_pkg;

  localparam logic [10:0] EPOCH_YEAR     = 11'd1970;
  localparam logic [8:0]  DAYS_YEAR      = 9'd365;
  localparam logic [8:0]  DAYS_LEAP_YEAR = 9'd366;
  localparam logic [16:0] MS_PER_SEC     = 17'd1000;
  localparam logic [16:0] HALF_SEC_MS    = 17'd500;
  localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
  localparam logic [16:0] SEC_PER_MIN    = 17'd60;
  localparam logic [16:0] DAYS_PER_WEEK  = 17'd7;
  localparam logic [15:0] EPOCH_WEEKDAY  = 16'd3;
  localparam logic [4:0]  HOURS_HALF_DAY = 5'd12;

  // floor(2^32 / divisor), the quotient estimate is low by at most one
  localparam logic [29:0] RECIP_MS_PER_SEC    = 30'd4294967;
  localparam logic [29:0] RECIP_SEC_PER_DAY   = 30'd49710;
  localparam logic [29:0] RECIP_SEC_PER_MIN   = 30'd71582788;
  localparam logic [29:0] RECIP_DAYS_PER_WEEK = 30'd613566756;

  // divide phases, counted down to zero
  localparam logic [1:0] DIV_PH_MUL = 2'd3;
  localparam logic [1:0] DIV_PH_REM = 2'd2;
  localparam logic [1:0] DIV_PH_FIX = 2'd1;

  typedef enum logic [1:0] {
    CFG_ZONE   = 2'd0,
    CFG_TWELVE = 2'd1,
    CFG_BLINK  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_STEP,
    DP_SPLIT_DAYS,
    DP_SPLIT_SOD,
    DP_SPLIT_MIN,
    DP_SPLIT_HOUR,
    DP_WEEKDAY,
    DP_YEAR_STEP,
    DP_MONTH_INIT,
    DP_MONTH_STEP,
    DP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_MS,
    S_DIV_DAY,
    S_DIV_SOD,
    S_DIV_MIN,
    S_DIV_WD,
    S_YEAR,
    S_MONTH,
    S_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [31:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  sec_of_minute;
    logic [5:0]  min_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_of_year;
    logic [10:0] calendar_year;
    logic [2:0]  weekday;
    logic [4:0]  display_hour;
    logic        is_pm;
    logic        colon_visible;
    logic        clamped_to_epoch;
  } out_item_t;

  typedef struct packed {
    logic [11:0] zone_offset_minutes;
    logic        twelve_hour;
    logic        blink_colon;
  } cfg_t;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic year_done;
    logic month_done;
  } stat_t;

  // within 1970..2099 the only century year is 2000, a leap year, so divisible by 4 is enough
  function automatic logic is_leap(input logic [10:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/e2ct_dpath.sv =====
module e2ct_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  e2ct_pkg::cmd_t      cmd_i,
  input  e2ct_pkg::cfg_t      cfg_i,
  input  e2ct_pkg::in_item_t  in_item_i,
  output e2ct_pkg::stat_t     stat_o,
  output e2ct_pkg::out_item_t out_item_o
);

  logic [31:0] base_q, base_d;
  logic [31:0] nm_q, nm_d;
  logic [31:0] dq_q, dq_d;
  logic [17:0] dr_q, dr_d;
  logic [16:0] dd_q, dd_d;
  logic [29:0] rc_q, rc_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [15:0] days_q, days_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [10:0] year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [2:0]  wd_q, wd_d;
  logic        colon_q, colon_d;
  logic        clamped_q, clamped_d;
  e2ct_pkg::out_item_t out_q, out_d;

  logic [61:0]        prod;
  logic [17:0]        qd;
  logic [31:0]        wall;
  logic signed [33:0] wall_s, zone_s, zone60_s, total_s;
  logic               leap;
  logic [8:0]         diy;
  logic [4:0]         mlen;
  logic [4:0]         hour12;

  // remainder is below twice the divisor, so 18 low bits are exact
  assign prod     = {30'd0, nm_q} * {32'd0, rc_q};
  assign qd       = dq_q[17:0] * {1'b0, dd_q};
  assign wall     = base_q + dq_q;
  assign wall_s   = $signed({{2{wall[31]}}, wall});
  assign zone_s   = $signed({{22{cfg_i.zone_offset_minutes[11]}}, cfg_i.zone_offset_minutes});
  assign zone60_s = (zone_s <<< 6) - (zone_s <<< 2);
  assign total_s  = wall_s + zone60_s;
  assign leap     = e2ct_pkg::is_leap(year_q);
  assign diy      = leap ? e2ct_pkg::DAYS_LEAP_YEAR : e2ct_pkg::DAYS_YEAR;
  assign mlen     = e2ct_pkg::month_len(month_q, leap);
  assign hour12   = (hour_q >= e2ct_pkg::HOURS_HALF_DAY) ? hour_q - e2ct_pkg::HOURS_HALF_DAY
                                                         : hour_q;

  assign stat_o.div_done   = (dcnt_q == 2'd0);
  assign stat_o.year_done  = (days_q < {7'd0, diy});
  assign stat_o.month_done = (days_q < {11'd0, mlen});

  always_comb begin
    base_d    = base_q;
    nm_d      = nm_q;
    dq_d      = dq_q;
    dr_d      = dr_q;
    dd_d      = dd_q;
    rc_d      = rc_q;
    dcnt_d    = dcnt_q;
    days_d    = days_q;
    sec_d     = sec_q;
    min_d     = min_q;
    hour_d    = hour_q;
    year_d    = year_q;
    month_d   = month_q;
    wd_d      = wd_q;
    colon_d   = colon_q;
    clamped_d = clamped_q;
    out_d     = out_q;
    case (cmd_i.op)
      e2ct_pkg::DP_LOAD: begin
        base_d = in_item_i.epoch_seconds;
        nm_d   = in_item_i.elapsed_ms;
        dd_d   = e2ct_pkg::MS_PER_SEC;
        rc_d   = e2ct_pkg::RECIP_MS_PER_SEC;
        dcnt_d = e2ct_pkg::DIV_PH_MUL;
      end
      e2ct_pkg::DP_DIV_STEP: begin
        case (dcnt_q)
          e2ct_pkg::DIV_PH_MUL: begin
            dq_d = {2'd0, prod[61:32]};
          end
          e2ct_pkg::DIV_PH_REM: begin
            dr_d = nm_q[17:0] - qd;
          end
          e2ct_pkg::DIV_PH_FIX: begin
            if (dr_q >= {1'b0, dd_q}) begin
              dq_d = dq_q + 32'd1;
              dr_d = dr_q - {1'b0, dd_q};
            end
          end
          default: begin
          end
        endcase
        dcnt_d = dcnt_q - 2'd1;
      end
      e2ct_pkg::DP_SPLIT_DAYS: begin
        colon_d   = !cfg_i.blink_colon || (dr_q < {1'b0, e2ct_pkg::HALF_SEC_MS});
        clamped_d = total_s[33];
        nm_d      = total_s[33] ? 32'd0 : total_s[31:0];
        dd_d      = e2ct_pkg::SEC_PER_DAY;
        rc_d      = e2ct_pkg::RECIP_SEC_PER_DAY;
        dcnt_d    = e2ct_pkg::DIV_PH_MUL;
      end
      e2ct_pkg::DP_SPLIT_SOD: begin
        days_d = dq_q[15:0];
        nm_d   = {15'd0, dr_q[16:0]};
        dd_d   = e2ct_pkg::SEC_PER_MIN;
        rc_d   = e2ct_pkg::RECIP_SEC_PER_MIN;
        dcnt_d = e2ct_pkg::DIV_PH_MUL;
      end
      e2ct_pkg::DP_SPLIT_MIN: begin
        sec_d  = dr_q[5:0];
        nm_d   = dq_q;
        dd_d   = e2ct_pkg::SEC_PER_MIN;
        rc_d   = e2ct_pkg::RECIP_SEC_PER_MIN;
        dcnt_d = e2ct_pkg::DIV_PH_MUL;
      end
      e2ct_pkg::DP_SPLIT_HOUR: begin
        min_d  = dr_q[5:0];
        hour_d = dq_q[4:0];
        nm_d   = {16'd0, days_q + e2ct_pkg::EPOCH_WEEKDAY};
        dd_d   = e2ct_pkg::DAYS_PER_WEEK;
        rc_d   = e2ct_pkg::RECIP_DAYS_PER_WEEK;
        dcnt_d = e2ct_pkg::DIV_PH_MUL;
      end
      e2ct_pkg::DP_WEEKDAY: begin
        wd_d   = dr_q[2:0];
        year_d = e2ct_pkg::EPOCH_YEAR;
      end
      e2ct_pkg::DP_YEAR_STEP: begin
        days_d = days_q - {7'd0, diy};
        year_d = year_q + 11'd1;
      end
      e2ct_pkg::DP_MONTH_INIT: begin
        month_d = 4'd1;
      end
      e2ct_pkg::DP_MONTH_STEP: begin
        days_d  = days_q - {11'd0, mlen};
        month_d = month_q + 4'd1;
      end
      e2ct_pkg::DP_EMIT: begin
        out_d.sec_of_minute    = sec_q;
        out_d.min_of_hour      = min_q;
        out_d.hour_of_day      = hour_q;
        out_d.day_of_month     = days_q[4:0] + 5'd1;
        out_d.month_of_year    = month_q;
        out_d.calendar_year    = year_q;
        out_d.weekday          = wd_q;
        out_d.display_hour     = !cfg_i.twelve_hour ? hour_q :
                                 (hour12 == 5'd0) ? e2ct_pkg::HOURS_HALF_DAY : hour12;
        out_d.is_pm            = (hour_q >= e2ct_pkg::HOURS_HALF_DAY);
        out_d.colon_visible    = colon_q;
        out_d.clamped_to_epoch = clamped_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    base_q    <= base_d;
    nm_q      <= nm_d;
    dq_q      <= dq_d;
    dr_q      <= dr_d;
    dd_q      <= dd_d;
    rc_q      <= rc_d;
    dcnt_q    <= dcnt_d;
    days_q    <= days_d;
    sec_q     <= sec_d;
    min_q     <= min_d;
    hour_q    <= hour_d;
    year_q    <= year_d;
    month_q   <= month_d;
    wd_q      <= wd_d;
    colon_q   <= colon_d;
    clamped_q <= clamped_d;
    out_q     <= out_d;
  end

  assign out_item_o = out_q;

  a_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == e2ct_pkg::DP_DIV_STEP |-> dcnt_q != 2'd0)
    else $error("divider stepped after its last phase");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == e2ct_pkg::DP_MONTH_INIT |-> year_q >= 11'd1970 && year_q <= 11'd2038)
    else $error("year walk left the supported range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == e2ct_pkg::DP_EMIT |-> days_q < 16'd31 && month_q >= 4'd1 && month_q <= 4'd12)
    else $error("month walk left an out of range day or month");

  a_sod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == e2ct_pkg::DP_SPLIT_SOD |-> dr_q < {1'b0, e2ct_pkg::SEC_PER_DAY})
    else $error("seconds of day out of range");

endmodule

// ===== rtl/e2ct_ctrl.sv =====
module e2ct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  e2ct_pkg::stat_t stat_i,
  output e2ct_pkg::cmd_t  cmd_o
);

  e2ct_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= e2ct_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o.op    = e2ct_pkg::DP_NOP;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      e2ct_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = e2ct_pkg::DP_LOAD;
          state_d  = e2ct_pkg::S_DIV_MS;
        end
      end
      e2ct_pkg::S_DIV_MS: begin
        if (!stat_i.div_done) begin
          cmd_o.op = e2ct_pkg::DP_DIV_STEP;
        end else begin
          cmd_o.op = e2ct_pkg::DP_SPLIT_DAYS;
          state_d  = e2ct_pkg::S_DIV_DAY;
        end
      end
      e2ct_pkg::S_DIV_DAY: begin
        if (!stat_i.div_done) begin
          cmd_o.op = e2ct_pkg::DP_DIV_STEP;
        end else begin
          cmd_o.op = e2ct_pkg::DP_SPLIT_SOD;
          state_d  = e2ct_pkg::S_DIV_SOD;
        end
      end
      e2ct_pkg::S_DIV_SOD: begin
        if (!stat_i.div_done) begin
          cmd_o.op = e2ct_pkg::DP_DIV_STEP;
        end else begin
          cmd_o.op = e2ct_pkg::DP_SPLIT_MIN;
          state_d  = e2ct_pkg::S_DIV_MIN;
        end
      end
      e2ct_pkg::S_DIV_MIN: begin
        if (!stat_i.div_done) begin
          cmd_o.op = e2ct_pkg::DP_DIV_STEP;
        end else begin
          cmd_o.op = e2ct_pkg::DP_SPLIT_HOUR;
          state_d  = e2ct_pkg::S_DIV_WD;
        end
      end
      e2ct_pkg::S_DIV_WD: begin
        if (!stat_i.div_done) begin
          cmd_o.op = e2ct_pkg::DP_DIV_STEP;
        end else begin
          cmd_o.op = e2ct_pkg::DP_WEEKDAY;
          state_d  = e2ct_pkg::S_YEAR;
        end
      end
      e2ct_pkg::S_YEAR: begin
        if (!stat_i.year_done) begin
          cmd_o.op = e2ct_pkg::DP_YEAR_STEP;
        end else begin
          cmd_o.op = e2ct_pkg::DP_MONTH_INIT;
          state_d  = e2ct_pkg::S_MONTH;
        end
      end
      e2ct_pkg::S_MONTH: begin
        if (!stat_i.month_done) begin
          cmd_o.op = e2ct_pkg::DP_MONTH_STEP;
        end else begin
          state_d = e2ct_pkg::S_EMIT;
        end
      end
      e2ct_pkg::S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = e2ct_pkg::DP_EMIT;
          out_valid_d = 1'b1;
          state_d     = e2ct_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = e2ct_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == e2ct_pkg::S_DIV_MS)
    else $error("accepted beat did not start a conversion");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == e2ct_pkg::DP_EMIT |=> out_valid_q && state_q == e2ct_pkg::S_IDLE)
    else $error("finished result not presented");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == e2ct_pkg::S_EMIT && out_valid_q && out_stall_i |=> state_q == e2ct_pkg::S_EMIT)
    else $error("result register overwritten while held");

endmodule

// ===== rtl/epoch_to_calendar_time_unit.sv =====
// channel  direction  handshake                   payload
// in       input      in_valid_i / in_stall_o     in_item_i (epoch_seconds, elapsed_ms)
// out      output     out_valid_o / out_stall_i   out_item_o (time fields and flags)
// cfg      input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// one beat at a time: from accept to result, five constant divides (reciprocal multiply,
// remainder, one correction, hand-off), a year walk at one year per cycle, a month walk
// at one month per cycle (up to 11 months), plus month setup, walk exit and result write
// a new beat can be taken once the result sits in the output register
// async active-low reset clears control and configuration, config writes always ready
// a held output stalls only the final write of the next result

module epoch_to_calendar_time_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  e2ct_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output e2ct_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);

  e2ct_pkg::cfg_t  cfg_q, cfg_d;
  e2ct_pkg::cmd_t  cmd;
  e2ct_pkg::stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        e2ct_pkg::CFG_ZONE:   cfg_d.zone_offset_minutes = cfg_data_i;
        e2ct_pkg::CFG_TWELVE: cfg_d.twelve_hour         = cfg_data_i[0];
        e2ct_pkg::CFG_BLINK:  cfg_d.blink_colon         = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  e2ct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  e2ct_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_item_i  (in_item_i),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule
